>>> rtl/rpi_pkg.sv
// ----------------------------------------------------------------------------
// rpi_pkg: shared types and widths for the ray/plane intersection checker
// Fixed-point formats, internal word widths and the structs that travel
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package rpi_pkg;

  localparam int COORD_W         = 32;
  localparam int UNIT_W          = 16;
  localparam int COORD_FRAC_BITS = 16;
  localparam int UNIT_FRAC_BITS  = 14;
  localparam int T_W             = 32;

  localparam int DEN_W     = 2 * UNIT_W + 2;
  localparam int NUM_W     = COORD_W + UNIT_W + 3;
  localparam int CMP_W     = NUM_W + DEN_W;
  localparam int RW        = DEN_W + 1;
  localparam int C_FULL_W  = T_W + UNIT_W + 2;
  localparam int C_W       = C_FULL_W - UNIT_FRAC_BITS;
  localparam int P_W       = C_W + UNIT_W;
  localparam int XY_W      = P_W + 2;
  localparam int ROUND_POS = COORD_FRAC_BITS + UNIT_FRAC_BITS;

  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;
  localparam int CNT_W   = 4;

  typedef struct packed {
    logic [47:0] normal;
    logic [47:0] u_axis;
    logic [47:0] v_axis;
    logic [31:0] offset;
    logic [31:0] half_w;
    logic [31:0] half_h;
    logic [1:0]  mode;
  } cfg_t;

  // Declared high to low so that origin_x lands in the lowest bits.
  typedef struct packed {
    logic [UNIT_W-1:0]  dir_z;
    logic [UNIT_W-1:0]  dir_y;
    logic [UNIT_W-1:0]  dir_x;
    logic [COORD_W-1:0] origin_z;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] origin_x;
  } ray_t;

  typedef struct packed {
    logic             miss;
    logic             sat;
    logic [NUM_W-1:0] an;
    logic [DEN_W-1:0] ad;
    ray_t             ray;
  } item_t;

  // Component k of a packed vector register, x in the top bits.
  function automatic logic signed [UNIT_W-1:0] axis_comp(input logic [47:0] r, input int k);
    return $signed(r[47-UNIT_W*k -: UNIT_W]);
  endfunction

endpackage

>>> rtl/ray_plane_intersect_checker_top.sv
// ----------------------------------------------------------------------------
// ray_plane_intersect_checker_top: ray versus configured plane intersection
// Register file, stream ports and the front/queue/back pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Rays enter on the s_ channel, one per transaction, and each produces
//   exactly one result transaction on the m_ channel, in order. A result
//   carries the hit flag, the distance t (unsigned Q16.16, saturated) and
//   the checker material select; a miss returns zeros for both.
//   The plane, frame axes, limits and mode sit in an APB register file at
//   byte address 8*i; the user must write them only while the block is idle,
//   and the block itself does not enforce this. A ray passes through three
//   front stages, the queue, a 32-stage divider that produces one quotient
//   bit per stage, and five projection stages. Throughput is one ray per cycle
//   while s_tready is high; the divider pipeline and the multiplier stages
//   take a new transaction every cycle unless the back end holds. When
//   m_tvalid is high and m_tready is low the whole back end holds; the front
//   end keeps taking rays until the 8-entry queue, counted with the rays
//   still in the front stages, is full, and then drops s_tready.
//   Reset (synchronous, active high) empties the pipeline and the queue and
//   returns the registers to n = (0,1,0), u = (1,0,0), v = (0,0,1), d = 0,
//   zero limits and mode 0. There is no clearing pass.
// ----------------------------------------------------------------------------
module ray_plane_intersect_checker_top import rpi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // s_tdata, from bit 0: origin_x[32], origin_y[32], origin_z[32],
  //                      dir_x[16], dir_y[16], dir_z[16]
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,
  // m_tdata, from bit 0: distance[32]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,
  // m_tuser, from bit 0: hit[1], material_select[1]
  output logic [1:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  typedef enum logic [2:0] {
    REG_NORMAL,
    REG_U_AXIS,
    REG_V_AXIS,
    REG_OFFSET,
    REG_HALF_W,
    REG_HALF_H,
    REG_MODE
  } reg_idx_t;

  localparam logic [47:0] NORMAL_RST = 48'h0000_4000_0000;
  localparam logic [47:0] U_AXIS_RST = 48'h4000_0000_0000;
  localparam logic [47:0] V_AXIS_RST = 48'h0000_0000_4000;

  cfg_t             cfg;
  logic             wr_en;
  reg_idx_t         reg_idx;

  logic             push;
  item_t            push_item;
  logic             q_pop;
  logic             q_valid;
  item_t            q_head;
  logic [CNT_W-1:0] q_count;

  logic             out_hit;
  logic             out_mat;
  logic [T_W-1:0]   out_dist;

  // Register file. The access phase of an APB write commits the data;
  // pready is tied high so every transfer completes without wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal <= NORMAL_RST;
      cfg.u_axis <= U_AXIS_RST;
      cfg.v_axis <= V_AXIS_RST;
      cfg.offset <= '0;
      cfg.half_w <= '0;
      cfg.half_h <= '0;
      cfg.mode   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NORMAL: cfg.normal <= pwdata[47:0];
        REG_U_AXIS: cfg.u_axis <= pwdata[47:0];
        REG_V_AXIS: cfg.v_axis <= pwdata[47:0];
        REG_OFFSET: cfg.offset <= pwdata[31:0];
        REG_HALF_W: cfg.half_w <= pwdata[31:0];
        REG_HALF_H: cfg.half_h <= pwdata[31:0];
        REG_MODE:   cfg.mode   <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NORMAL: prdata = {16'd0, cfg.normal};
      REG_U_AXIS: prdata = {16'd0, cfg.u_axis};
      REG_V_AXIS: prdata = {16'd0, cfg.v_axis};
      REG_OFFSET: prdata = {32'd0, cfg.offset};
      REG_HALF_W: prdata = {32'd0, cfg.half_w};
      REG_HALF_H: prdata = {32'd0, cfg.half_h};
      REG_MODE:   prdata = {62'd0, cfg.mode};
      default:    prdata = '0;
    endcase
  end

  // Front end: products, sums, miss classification and saturation check.
  rpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_ray    (ray_t'(s_tdata)),
    .cfg       (cfg),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  // Queue that lets the back end stall without backing into the front end.
  rpi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head),
    .count     (q_count)
  );

  // Back end: division, hit point, projection and the output register.
  rpi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_hit   (out_hit),
    .out_dist  (out_dist),
    .out_mat   (out_mat)
  );

  assign m_tdata = out_dist;
  assign m_tuser = {out_mat, out_hit};

endmodule

>>> rtl/rpi_front.sv
// ----------------------------------------------------------------------------
// rpi_front: ray intake and classification
// Forms the denominator n.r and numerator -(o.n + d), flags misses, takes
// magnitudes and detects distance saturation before handing off to the queue.
// ----------------------------------------------------------------------------
module rpi_front import rpi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ray_t             in_ray,
  input  cfg_t             cfg,
  input  logic [CNT_W-1:0] q_count,
  output logic             push,
  output item_t            push_item
);

  logic signed [COORD_W-1:0] o [3];
  logic signed [UNIT_W-1:0]  r [3];
  logic signed [UNIT_W-1:0]  n [3];

  logic                             f1_v;
  ray_t                             f1_ray;
  logic signed [COORD_W+UNIT_W-1:0] f1_on [3];
  logic signed [2*UNIT_W-1:0]       f1_dp [3];

  logic                    f2_v;
  ray_t                    f2_ray;
  logic signed [DEN_W-1:0] f2_den;
  logic signed [NUM_W-1:0] f2_num;

  logic                    f3_v;
  item_t                   f3_item;

  logic signed [NUM_W-1:0] d_wide;
  logic signed [NUM_W-1:0] d_sh;
  logic                    miss;
  logic [NUM_W-1:0]        an;
  logic [DEN_W-1:0]        ad;
  logic [CMP_W-1:0]        an_c;
  logic [CMP_W-1:0]        ad_c;
  logic [CNT_W:0]          used;

  assign o[0] = $signed(in_ray.origin_x);
  assign o[1] = $signed(in_ray.origin_y);
  assign o[2] = $signed(in_ray.origin_z);
  assign r[0] = $signed(in_ray.dir_x);
  assign r[1] = $signed(in_ray.dir_y);
  assign r[2] = $signed(in_ray.dir_z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i] = axis_comp(cfg.normal, i);
    end
  end

  // Items in flight plus queued items never exceed the queue depth, so the
  // front end itself never has to stall.
  assign used = {1'b0, q_count} + (CNT_W+1)'(f1_v) + (CNT_W+1)'(f2_v) + (CNT_W+1)'(f3_v);
  assign in_ready = used < (CNT_W+1)'(Q_DEPTH);

  assign d_wide = NUM_W'($signed(cfg.offset));
  assign d_sh   = d_wide <<< UNIT_FRAC_BITS;

  assign miss = (f2_den == '0) ||
                ((f2_num != '0) && (f2_num[NUM_W-1] != f2_den[DEN_W-1]));
  assign an   = f2_num[NUM_W-1] ? NUM_W'(-f2_num) : NUM_W'(f2_num);
  assign ad   = f2_den[DEN_W-1] ? DEN_W'(-f2_den) : DEN_W'(f2_den);
  assign an_c = CMP_W'(an);
  assign ad_c = CMP_W'(ad) << (T_W - UNIT_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
    end else begin
      f1_v <= in_valid && in_ready;
      f2_v <= f1_v;
      f3_v <= f2_v;
    end
  end

  always_ff @(posedge clk) begin
    f1_ray <= in_ray;
    for (int i = 0; i < 3; i++) begin
      f1_on[i] <= (COORD_W+UNIT_W)'(o[i]) * (COORD_W+UNIT_W)'(n[i]);
      f1_dp[i] <= (2*UNIT_W)'(r[i]) * (2*UNIT_W)'(n[i]);
    end
    f2_ray <= f1_ray;
    f2_den <= DEN_W'(f1_dp[0]) + DEN_W'(f1_dp[1]) + DEN_W'(f1_dp[2]);
    f2_num <= -(NUM_W'(f1_on[0]) + NUM_W'(f1_on[1]) + NUM_W'(f1_on[2]) + d_sh);
    f3_item.miss <= miss;
    f3_item.sat  <= an_c >= ad_c;
    f3_item.an   <= an;
    f3_item.ad   <= ad;
    f3_item.ray  <= f2_ray;
  end

  assign push      = f3_v;
  assign push_item = f3_item;

endmodule

>>> rtl/rpi_queue.sv
// ----------------------------------------------------------------------------
// rpi_queue: short queue between the front end and the back end
// A small circular buffer with a fill count; reads are combinational.
// ----------------------------------------------------------------------------
module rpi_queue import rpi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  item_t            push_item,
  input  logic             pop,
  output logic             not_empty,
  output item_t            head,
  output logic [CNT_W-1:0] count
);

  item_t            mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;

  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < CNT_W'(Q_DEPTH)))
    else $error("queue written while full");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a write");
`endif

endmodule

>>> rtl/rpi_back.sv
// ----------------------------------------------------------------------------
// rpi_back: distance division, hit point projection and material select
// A one-bit-per-stage divider pipeline followed by the hit point, frame
// projection, extent check and checker parity stages.
// ----------------------------------------------------------------------------
module rpi_back import rpi_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  item_t          q_item,
  output logic           q_pop,
  input  cfg_t           cfg,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           out_hit,
  output logic [T_W-1:0] out_dist,
  output logic           out_mat
);

  localparam int MODE_LIMITED = 0;
  localparam int MODE_SINGLE  = 1;

  typedef struct packed {
    logic             v;
    logic             miss;
    logic             sat;
    logic [RW-1:0]    rem;
    logic [T_W-1:0]   nlow;
    logic [T_W-1:0]   q;
    logic [DEN_W-1:0] ad;
    ray_t             ray;
  } div_t;

  logic en;

  div_t          dv    [T_W];
  div_t          dv_in [T_W];
  div_t          dv_nx [T_W];
  logic [RW-1:0] trial [T_W];
  logic          ge    [T_W];

  logic signed [COORD_W-1:0] o  [3];
  logic signed [UNIT_W-1:0]  r  [3];
  logic signed [UNIT_W-1:0]  n  [3];
  logic signed [UNIT_W-1:0]  ua [3];
  logic signed [UNIT_W-1:0]  va [3];
  logic signed [COORD_W-1:0] d;
  logic [T_W-1:0]            t;

  logic                             p1_v, p1_miss;
  logic [T_W-1:0]                   p1_t;
  logic signed [COORD_W-1:0]        p1_o  [3];
  logic signed [T_W+UNIT_W:0]       p1_tr [3];
  logic signed [COORD_W+UNIT_W-1:0] p1_dn [3];

  logic signed [C_FULL_W-1:0] cf   [3];
  logic signed [C_FULL_W-1:0] o_sh [3];

  logic                  p2_v, p2_miss;
  logic [T_W-1:0]        p2_t;
  logic signed [C_W-1:0] p2_c [3];

  logic                  p3_v, p3_miss;
  logic [T_W-1:0]        p3_t;
  logic signed [P_W-1:0] p3_cu [3];
  logic signed [P_W-1:0] p3_cv [3];

  logic                   p4_v, p4_miss;
  logic [T_W-1:0]         p4_t;
  logic signed [XY_W-1:0] p4_x, p4_y;

  logic signed [XY_W:0] hws, hhs, xw, yw;
  logic [XY_W-1:0]      ax, ay;
  logic [XY_W:0]        rsx, rsy;
  logic                 outside, hit, mat;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  // Divider: the partial remainder starts from the high quotient-free bits of
  // an << U and takes one dividend bit per stage.
  always_comb begin
    dv_in[0].v    = q_pop;
    dv_in[0].miss = q_item.miss;
    dv_in[0].sat  = q_item.sat;
    dv_in[0].rem  = RW'(q_item.an >> (T_W - UNIT_FRAC_BITS));
    dv_in[0].nlow = T_W'(q_item.an << UNIT_FRAC_BITS);
    dv_in[0].q    = '0;
    dv_in[0].ad   = q_item.ad;
    dv_in[0].ray  = q_item.ray;
    for (int k = 1; k < T_W; k++) begin
      dv_in[k] = dv[k-1];
    end
    for (int k = 0; k < T_W; k++) begin
      trial[k] = {dv_in[k].rem[RW-2:0], dv_in[k].nlow[T_W-1]};
      ge[k]    = trial[k] >= RW'(dv_in[k].ad);
      dv_nx[k] = dv_in[k];
      dv_nx[k].rem  = ge[k] ? (trial[k] - RW'(dv_in[k].ad)) : trial[k];
      dv_nx[k].nlow = dv_in[k].nlow << 1;
      dv_nx[k].q    = {dv_in[k].q[T_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < T_W; k++) begin
        dv[k].v <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < T_W; k++) begin
        dv[k] <= dv_nx[k];
      end
    end
  end

  assign o[0] = $signed(dv[T_W-1].ray.origin_x);
  assign o[1] = $signed(dv[T_W-1].ray.origin_y);
  assign o[2] = $signed(dv[T_W-1].ray.origin_z);
  assign r[0] = $signed(dv[T_W-1].ray.dir_x);
  assign r[1] = $signed(dv[T_W-1].ray.dir_y);
  assign r[2] = $signed(dv[T_W-1].ray.dir_z);
  assign d    = $signed(cfg.offset);
  assign t    = dv[T_W-1].sat ? '1 : dv[T_W-1].q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i]    = axis_comp(cfg.normal, i);
      ua[i]   = axis_comp(cfg.u_axis, i);
      va[i]   = axis_comp(cfg.v_axis, i);
      o_sh[i] = C_FULL_W'(p1_o[i]);
      o_sh[i] = o_sh[i] <<< UNIT_FRAC_BITS;
      cf[i]   = o_sh[i] + C_FULL_W'(p1_tr[i]) + C_FULL_W'(p1_dn[i]);
    end
  end

  // Extent check and checker parity on the projected coordinates.
  assign hws = $signed({{(XY_W+1-COORD_W-UNIT_FRAC_BITS){1'b0}}, cfg.half_w,
                        {UNIT_FRAC_BITS{1'b0}}});
  assign hhs = $signed({{(XY_W+1-COORD_W-UNIT_FRAC_BITS){1'b0}}, cfg.half_h,
                        {UNIT_FRAC_BITS{1'b0}}});
  assign xw  = (XY_W+1)'(p4_x);
  assign yw  = (XY_W+1)'(p4_y);
  assign outside = (xw > hws) || (xw < -hws) || (yw > hhs) || (yw < -hhs);
  assign ax  = p4_x[XY_W-1] ? XY_W'(-p4_x) : XY_W'(p4_x);
  assign ay  = p4_y[XY_W-1] ? XY_W'(-p4_y) : XY_W'(p4_y);
  assign rsx = {1'b0, ax} + ((XY_W+1)'(1) << (ROUND_POS - 1));
  assign rsy = {1'b0, ay} + ((XY_W+1)'(1) << (ROUND_POS - 1));
  assign hit = !p4_miss && !(cfg.mode[MODE_LIMITED] && outside);
  assign mat = !cfg.mode[MODE_SINGLE] && (rsx[ROUND_POS] ^ rsy[ROUND_POS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      p3_v      <= 1'b0;
      p4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_v      <= dv[T_W-1].v;
      p2_v      <= p1_v;
      p3_v      <= p2_v;
      p4_v      <= p3_v;
      out_valid <= p4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_miss <= dv[T_W-1].miss;
      p1_t    <= t;
      for (int i = 0; i < 3; i++) begin
        p1_o[i]  <= o[i];
        p1_tr[i] <= (T_W+UNIT_W+1)'($signed({1'b0, t})) * (T_W+UNIT_W+1)'(r[i]);
        p1_dn[i] <= (COORD_W+UNIT_W)'(d) * (COORD_W+UNIT_W)'(n[i]);
      end
      p2_miss <= p1_miss;
      p2_t    <= p1_t;
      for (int i = 0; i < 3; i++) begin
        p2_c[i] <= $signed(cf[i][C_FULL_W-1:UNIT_FRAC_BITS]);
      end
      p3_miss <= p2_miss;
      p3_t    <= p2_t;
      for (int i = 0; i < 3; i++) begin
        p3_cu[i] <= P_W'(p2_c[i]) * P_W'(ua[i]);
        p3_cv[i] <= P_W'(p2_c[i]) * P_W'(va[i]);
      end
      p4_miss <= p3_miss;
      p4_t    <= p3_t;
      p4_x    <= XY_W'(p3_cu[0]) + XY_W'(p3_cu[1]) + XY_W'(p3_cu[2]);
      p4_y    <= XY_W'(p3_cv[0]) + XY_W'(p3_cv[1]) + XY_W'(p3_cv[2]);
      out_hit  <= hit;
      out_dist <= hit ? p4_t : '0;
      out_mat  <= hit && mat;
    end
  end

`ifndef ASSERT_OFF
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_hit) |-> ((out_dist == '0) && !out_mat))
    else $error("miss result carries a distance or material");
`endif

endmodule
